### src/sha_pkg.sv
// Package with shared SHA-256 types, constants and the round constant table.
package sha_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned CntW  = 61;

  typedef logic [WordW-1:0] word_t;

  // Control from the sequencer to the compression core.
  typedef struct packed {
    logic start;   // Begin one 64-round compression of the block buffer.
    logic init;    // Load the initial chaining value.
  } core_ctl_t;

  localparam word_t PadByteWord = 32'h0000_0080;

  function automatic word_t init_h(input logic [2:0] i);
    word_t r;
    case (i)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  function automatic word_t round_k(input logic [5:0] i);
    word_t r;
    case (i)
      6'd0:  r = 32'h428a2f98; 6'd1:  r = 32'h71374491;
      6'd2:  r = 32'hb5c0fbcf; 6'd3:  r = 32'he9b5dba5;
      6'd4:  r = 32'h3956c25b; 6'd5:  r = 32'h59f111f1;
      6'd6:  r = 32'h923f82a4; 6'd7:  r = 32'hab1c5ed5;
      6'd8:  r = 32'hd807aa98; 6'd9:  r = 32'h12835b01;
      6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
      6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
      6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
      6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
      6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
      6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
      6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
      6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
      6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
      6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
      6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
      6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
      6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
      6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
      6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
      6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
      6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
      6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
      6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
      6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
      6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
      6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
      6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
      6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
      6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
      6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
      6'd62: r = 32'hbef9a3f7; default: r = 32'hc67178f2;
    endcase
    return r;
  endfunction

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (WordW - n));
  endfunction

endpackage

### src/sha256_hash_engine_top.sv
// Top level of the SHA-256 engine: byte packing, padding sequencer and digest output.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall   | msg_byte, has_byte, end_of_message
//   out_    | output    | out_valid/out_stall | digest_word, word_number, last_word
//
// A byte that does not complete a block leaves the engine idle and ready for the next byte.
// The 64th byte of a block holds the input while the core runs its 64 rounds.
// End of message holds the input while one or two padding blocks are written and compressed,
// then while the eight digest words go out, including any time spent in out_stall.
// rst_n is synchronous; it restores the initial hash words and a zero byte count.
module sha256_hash_engine_top
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_msg_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_number,
  output logic        out_last_word
);

  typedef enum logic [1:0] {S_IDLE, S_COMP, S_PAD, S_OUT} state_t;

  state_t          st_r;
  logic [CntW-1:0] cnt_r;
  word_t           wacc_r;
  logic            end_pend_r;
  logic            pad_act_r;
  logic            len_blk_r;
  logic [3:0]      pad_idx_r;
  logic [2:0]      out_k_r;
  logic            out_valid_r;
  word_t           out_word_r;
  logic [2:0]      out_num_r;
  logic            out_last_r;

  core_ctl_t  ctl;
  logic       wr_en;
  logic [3:0] wr_addr;
  word_t      wr_data;
  logic [3:0] rd_addr;
  word_t      rd_data;
  logic       core_done;
  word_t      chain_word;

  logic       in_xfer;
  logic [5:0] pos;
  logic [4:0] sh;
  word_t      byte_word;
  word_t      pad_word;
  logic [63:0] bit_len;
  logic       out_load;

  assign in_stall = (st_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign pos      = cnt_r[5:0];
  assign sh       = {~pos[1:0], 3'b000};
  assign bit_len  = {cnt_r, 3'b000};
  assign out_load = !out_valid_r || !out_stall;

  always_comb begin
    byte_word = ((pos[1:0] == 2'd0) ? '0 : wacc_r) | (word_t'(in_msg_byte) << sh);
    pad_word  = ((pos[1:0] == 2'd0) ? '0 : wacc_r) | (PadByteWord << sh);
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pos[5:2];
    wr_data = byte_word;
    ctl     = '0;
    case (st_r)
      S_IDLE: begin
        wr_en     = in_xfer && in_has_byte && (pos[1:0] == 2'd3);
        ctl.start = in_xfer && in_has_byte && (pos == 6'd63);
      end
      S_PAD: begin
        wr_en   = 1'b1;
        wr_addr = pad_idx_r;
        if (!len_blk_r || pad_act_r) begin
          wr_data = '0;
        end
        // The word that holds the marker byte appears only in the first padding block.
        if (pad_idx_r == pos[5:2] && pad_act_r) begin
          wr_data = pad_word;
        end else if (len_blk_r && pad_idx_r == 4'd14) begin
          wr_data = bit_len[63:32];
        end else if (len_blk_r && pad_idx_r == 4'd15) begin
          wr_data = bit_len[31:0];
        end else begin
          wr_data = '0;
        end
        ctl.start = (pad_idx_r == 4'd15);
      end
      S_OUT: begin
        ctl.init = out_load && (out_k_r == 3'd7);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      cnt_r       <= '0;
      end_pend_r  <= 1'b0;
      pad_act_r   <= 1'b0;
      len_blk_r   <= 1'b0;
      pad_idx_r   <= '0;
      out_k_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= (st_r == S_OUT);
      end
      case (st_r)
        S_IDLE: begin
          if (in_xfer) begin
            end_pend_r <= in_end_of_message;
            if (in_has_byte) begin
              wacc_r <= byte_word;
              cnt_r  <= cnt_r + CntW'(1);
            end
            if (in_has_byte && pos == 6'd63) begin
              st_r <= S_COMP;
            end else if (in_end_of_message) begin
              st_r <= S_PAD;
            end
            // The padding start is taken from the count after this byte.
            pad_act_r <= 1'b1;
            pad_idx_r <= in_has_byte ? (pos[1:0] == 2'd3 ? pos[5:2] + 4'd1 : pos[5:2])
                                     : pos[5:2];
            len_blk_r <= ((in_has_byte ? 6'(pos + 6'd1) : pos) < 6'd56)
                      && !(in_has_byte && pos == 6'd63);
          end
        end
        S_PAD: begin
          pad_idx_r <= pad_idx_r + 4'd1;
          if (pad_idx_r == 4'd15) begin
            st_r <= S_COMP;
          end
        end
        S_COMP: begin
          if (core_done) begin
            if (!end_pend_r) begin
              st_r <= S_IDLE;
            end else if (pad_act_r && pad_idx_r == 4'd0 && cnt_r[5:0] == 6'd0
                         && !len_blk_r && 1'b0) begin
              st_r <= S_IDLE;
            end else if (len_blk_r && !pad_act_r) begin
              st_r    <= S_OUT;
              out_k_r <= '0;
            end else if (!pad_act_r) begin
              st_r <= S_OUT;
            end else if (cnt_r[5:0] == 6'd0 && pad_idx_r == 4'd0 && !len_blk_r) begin
              // A full data block closed the message; marker and length share the next block.
              len_blk_r <= 1'b1;
              st_r      <= S_PAD;
            end else if (len_blk_r) begin
              pad_act_r <= 1'b0;
              st_r      <= S_OUT;
              out_k_r   <= '0;
            end else begin
              // Marker and zero fill are done; the length goes in a block of its own.
              pad_act_r <= 1'b0;
              len_blk_r <= 1'b1;
              pad_idx_r <= '0;
              st_r      <= S_PAD;
            end
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_word_r  <= chain_word;
            out_num_r   <= out_k_r;
            out_last_r  <= (out_k_r == 3'd7);
            out_k_r     <= out_k_r + 3'd1;
            if (out_k_r == 3'd7) begin
              cnt_r      <= '0;
              end_pend_r <= 1'b0;
              st_r       <= S_IDLE;
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_digest_word = out_word_r;
  assign out_word_number = out_num_r;
  assign out_last_word   = out_last_r;

  sha_blkbuf u_blkbuf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sha_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .done       (core_done),
    .sel        (out_k_r),
    .chain_word (chain_word)
  );

endmodule

### src/sha_blkbuf.sv
// Sixteen-word message block buffer with one write port and a registered read port.
module sha_blkbuf
  import sha_pkg::*;
(
  input  logic       clk,
  input  logic       wr_en,
  input  logic [3:0] wr_addr,
  input  word_t      wr_data,
  input  logic [3:0] rd_addr,
  output word_t      rd_data
);

  word_t mem [16];
  word_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

### src/sha_core.sv
// SHA-256 compression core: one round per cycle, schedule window and chaining value.
module sha_core
  import sha_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  core_ctl_t  ctl,
  output logic [3:0] rd_addr,
  input  word_t      rd_data,
  output logic       done,
  input  logic [2:0] sel,
  output word_t      chain_word
);

  typedef enum logic [1:0] {S_IDLE, S_LOAD, S_RUN, S_FIN} state_t;

  state_t     st_r;
  logic [5:0] t_r;
  word_t      v_r     [8];
  word_t      chain_r [8];
  word_t      w_r     [16];

  word_t wt, w_calc, s0, s1, t1, t2, e, a;

  always_comb begin
    s0     = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1     = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    w_calc = s1 + w_r[9] + s0 + w_r[0];
    // The first sixteen rounds take their word straight from the block buffer.
    wt     = (t_r[5:4] == 2'b00) ? rd_data : w_calc;
    e      = v_r[4];
    a      = v_r[0];
    t1     = v_r[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
           + ((e & v_r[5]) ^ (~e & v_r[6])) + round_k(t_r) + wt;
    t2     = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
           + ((a & v_r[1]) ^ (a & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  assign rd_addr    = (st_r == S_LOAD) ? 4'd0 : (t_r[3:0] + 4'd1);
  assign done       = (st_r == S_FIN);
  assign chain_word = chain_r[sel];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      t_r  <= '0;
      for (int i = 0; i < 8; i++) begin
        chain_r[i] <= init_h(3'(i));
      end
    end else begin
      case (st_r)
        S_IDLE: begin
          if (ctl.start) begin
            for (int i = 0; i < 8; i++) begin
              v_r[i] <= chain_r[i];
            end
            st_r <= S_LOAD;
          end
          if (ctl.init) begin
            for (int i = 0; i < 8; i++) begin
              chain_r[i] <= init_h(3'(i));
            end
          end
        end
        S_LOAD: begin
          t_r  <= '0;
          st_r <= S_RUN;
        end
        S_RUN: begin
          for (int i = 0; i < 15; i++) begin
            w_r[i] <= w_r[i+1];
          end
          w_r[15] <= wt;
          v_r[7] <= v_r[6];
          v_r[6] <= v_r[5];
          v_r[5] <= v_r[4];
          v_r[4] <= v_r[3] + t1;
          v_r[3] <= v_r[2];
          v_r[2] <= v_r[1];
          v_r[1] <= v_r[0];
          v_r[0] <= t1 + t2;
          t_r    <= t_r + 6'd1;
          if (t_r == 6'd63) begin
            st_r <= S_FIN;
          end
        end
        S_FIN: begin
          for (int i = 0; i < 8; i++) begin
            chain_r[i] <= chain_r[i] + v_r[i];
          end
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

endmodule

### src/sha_checker.sv
// Port-level checker for the SHA-256 engine and its bind to the top level.
module sha_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_digest_word,
  input logic [2:0]  out_word_number,
  input logic        out_last_word
);

  a_last_is_seven: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_word == (out_word_number == 3'd7)))
    else $error("last_word flag does not match word number");

  a_first_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> (out_word_number == 3'd0))
    else $error("digest run did not start at word zero");

  a_no_input_mid_digest: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_last_word) |-> in_stall)
    else $error("input accepted while a digest is being sent");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_digest_word)))
    else $error("stalled digest word changed");

endmodule

bind sha256_hash_engine_top sha_checker u_sha_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_digest_word (out_digest_word),
  .out_word_number (out_word_number),
  .out_last_word   (out_last_word)
);

### tb/sv/sha256_digest_checker.sv
// Checker that predicts SHA-256 digest words from observed input transfers and compares them.
module sha256_digest_checker
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_msg_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] out_digest_word,
  input  logic [2:0]  out_word_number,
  input  logic        out_last_word,
  output int          fail_count,
  output int          pending_words,
  output int          digests_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_item_t;

  localparam logic [31:0] IvWords [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
  localparam logic [31:0] KTable [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

  logic [31:0]  hash_state [8];
  logic [31:0]  blk [16];
  logic [60:0]  byte_count;
  digest_item_t digest_queue [$];

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++) w[i] = blk[i];
    for (int i = 16; i < 64; i++) begin
      w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
           + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    end
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTable[i] + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic place_byte(int pos, logic [7:0] b);
    int sh;
    sh = (3 - (pos % 4)) * 8;
    if (pos % 4 == 0) blk[pos/4] = 32'(b) << sh;
    else blk[pos/4] |= 32'(b) << sh;
  endtask

  task automatic absorb_item(logic [7:0] b, logic has, logic eom);
    int pos;
    logic [63:0] bits;
    digest_item_t d;
    if (has) begin
      pos = int'(byte_count[5:0]);
      place_byte(pos, b);
      byte_count++;
      if (pos == 63) compress();
    end
    if (eom) begin
      pos = int'(byte_count[5:0]);
      bits = {byte_count, 3'b000};
      place_byte(pos, 8'h80);
      for (int i = pos / 4 + 1; i < 16; i++) blk[i] = '0;
      if (pos >= 56) begin
        compress();
        for (int i = 0; i < 16; i++) blk[i] = '0;
      end
      blk[14] = bits[63:32];
      blk[15] = bits[31:0];
      compress();
      for (int i = 0; i < 8; i++) begin
        d.word = hash_state[i];
        d.idx = 3'(i);
        d.last = (i == 7);
        digest_queue.push_back(d);
      end
      for (int i = 0; i < 8; i++) hash_state[i] = IvWords[i];
      byte_count = '0;
    end
  endtask

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    digests_seen = 0;
    pending_words = 0;
    for (int i = 0; i < 8; i++) hash_state[i] = IvWords[i];
    byte_count = '0;
  end

  always @(posedge clk) begin
    digest_item_t exp_d;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (digest_queue.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h", out_digest_word));
        end else begin
          exp_d = digest_queue.pop_front();
          if (out_digest_word !== exp_d.word)
            report_mismatch($sformatf("word %0d got %h exp %h", exp_d.idx,
                                      out_digest_word, exp_d.word));
          if (out_word_number !== exp_d.idx)
            report_mismatch($sformatf("index got %0d exp %0d", out_word_number, exp_d.idx));
          if (out_last_word !== exp_d.last)
            report_mismatch($sformatf("last flag got %b exp %b", out_last_word, exp_d.last));
          if (exp_d.last) digests_seen++;
        end
      end
      if (in_valid && !in_stall) absorb_item(in_msg_byte, in_has_byte, in_end_of_message);
    end
    pending_words = digest_queue.size();
  end
endmodule

### tb/sv/tb.sv
// Top of the SHA-256 engine testbench: clock, reset, stimulus and verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 5000;

  logic        clk, rst_n;
  logic        in_valid, in_stall, in_has_byte, in_end_of_message;
  logic [7:0]  in_msg_byte;
  logic        out_valid, out_stall, out_last_word;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_number;
  int          fail_count, pending_words, digests_seen;
  int          item_count;
  int          idle_cycles;
  bit          calm_phase;
  bit          hold_sink;

  sha256_hash_engine_top u_dut (.*);

  sha256_digest_checker u_chk (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Sends one item and waits for its transfer; random gaps come first.
  task automatic send_item(logic [7:0] b, logic has, logic eom);
    int gap;
    if (!calm_phase && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid <= 1'b0;
      in_msg_byte <= 8'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_msg_byte <= b;
    in_has_byte <= has;
    in_end_of_message <= eom;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    item_count++;
  endtask

  task automatic send_message(int len, bit end_alone);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, (i == len - 1) && !end_alone);
    end
    if (end_alone || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  // Receiver stall: random bursts, a long hold when requested, none in the calm phase.
  initial begin
    out_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_sink) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_sink = 1'b0;
      end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog expired after %0d quiet cycles", IdleLimit);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int len;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_msg_byte = 8'h00;
    in_has_byte = 1'b0;
    in_end_of_message = 1'b0;
    calm_phase = 1'b0;
    hold_sink = 1'b0;
    item_count = 0;
    idle_cycles = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty message, idle and stray bytes, extremes, the 55/56 padding boundary.
    send_item(8'hff, 1'b0, 1'b1);
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'h5a, 1'b0, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_message(55, 1'b0);
    send_message(56, 1'b1);
    send_message(64, 1'b0);

    // The sink holds off while several messages queue up behind it.
    hold_sink = 1'b1;
    for (int m = 0; m < 4; m++) send_message($urandom_range(0, 3), $urandom_range(0, 1));

    while (item_count < 270) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 130) : $urandom_range(0, 20);
      if (len > 275 - item_count) len = 275 - item_count;
      if (item_count > 230) calm_phase = 1'b1;
      send_message(len, $urandom_range(0, 3) == 0);
    end
    in_valid <= 1'b0;

    repeat (2) @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d input transfers and %0d digests, incl. empty and block-edge messages",
             item_count, digests_seen);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
